>>> rtl/core/fbsm_pkg.sv
`timescale 1ns / 1ps

package fbsm_pkg;

    // Default slot count; the top level takes it as a parameter.
    localparam int NUM_SLOTS_DEF = 2;

    // Field widths fixed by the item and result formats.
    localparam int OP_W        = 2;
    localparam int SLOT_W      = 1;
    localparam int SEQ_W       = 32;
    localparam int MASK_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 40;

    // Slot status codes.
    localparam logic [STATUS_W-1:0] ST_FREE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_WRITING   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_READY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IN_FLIGHT = 2'd3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_FINISH  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_ENABLE   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENT_MASK = 1'd1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic              ready_req;
        logic              frozen;
    } item_t;

    typedef struct packed {
        logic              done_ok;
        logic [SLOT_W-1:0] out_slot;
        logic [SEQ_W-1:0]  out_sequence;
    } result_t;

endpackage

>>> rtl/core/fbsm_step.sv
`timescale 1ns / 1ps

// Next-state and result logic for one operation, applied to the current
// slot table in a single pass.
module fbsm_step #(
    parameter int NUM_SLOTS = fbsm_pkg::NUM_SLOTS_DEF
) (
    input  fbsm_pkg::item_t                     item,
    input  logic                                run_enable,
    input  logic [fbsm_pkg::MASK_W-1:0]         present_mask,
    input  logic [fbsm_pkg::STATUS_W-1:0]       status [NUM_SLOTS],
    input  logic [fbsm_pkg::SEQ_W-1:0]          stamp [NUM_SLOTS],
    input  logic [fbsm_pkg::SEQ_W-1:0]          counter,
    output logic [fbsm_pkg::STATUS_W-1:0]       status_next [NUM_SLOTS],
    output logic [fbsm_pkg::SEQ_W-1:0]          stamp_next [NUM_SLOTS],
    output logic [fbsm_pkg::SEQ_W-1:0]          counter_next,
    output fbsm_pkg::result_t                   result
);
    import fbsm_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);

    logic [NUM_SLOTS-1:0] present;
    logic [IDX_W-1:0]     sidx;
    logic [SEQ_W-1:0]     counter_inc;
    logic                 found;
    logic [IDX_W-1:0]     sel;
    logic [SEQ_W-1:0]     newest;

    // Slots beyond the mask width never have storage.
    assign present     = NUM_SLOTS'(present_mask);
    assign sidx        = IDX_W'(item.slot);
    assign counter_inc = counter + SEQ_W'(1);

    always_comb
    begin
        status_next         = status;
        stamp_next          = stamp;
        counter_next        = counter;
        result.done_ok      = 1'b0;
        result.out_slot     = item.slot;
        result.out_sequence = '0;
        found               = 1'b0;
        sel                 = '0;
        newest              = '0;

        unique case (item.op)
            OP_ACQUIRE:
            begin
                if (run_enable)
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (!found && present[i] && status[i] == ST_FREE)
                        begin
                            found           = 1'b1;
                            status_next[i]  = ST_WRITING;
                            result.done_ok  = 1'b1;
                            result.out_slot = SLOT_W'(i);
                        end
                    end
                end
            end
            OP_FINISH:
            begin
                if (status[sidx] == ST_WRITING)
                begin
                    result.done_ok = 1'b1;
                    if (item.ready_req && run_enable)
                    begin
                        counter_next        = counter_inc;
                        stamp_next[sidx]    = counter_inc;
                        status_next[sidx]   = ST_READY;
                        result.out_sequence = counter_inc;
                    end
                    else
                    begin
                        status_next[sidx] = ST_FREE;
                    end
                end
            end
            OP_TICK:
            begin
                if (run_enable)
                begin
                    if (item.frozen)
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (status[i] == ST_READY)
                            begin
                                status_next[i] = ST_FREE;
                            end
                        end
                    end
                    else
                    begin
                        // Strictly greater wins, so the lower slot keeps ties.
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (present[i] && status[i] == ST_READY &&
                                (!found || stamp[i] > newest))
                            begin
                                found  = 1'b1;
                                sel    = IDX_W'(i);
                                newest = stamp[i];
                            end
                        end
                        if (found)
                        begin
                            for (int i = 0; i < NUM_SLOTS; i++)
                            begin
                                if (IDX_W'(i) != sel && status[i] == ST_READY)
                                begin
                                    status_next[i] = ST_FREE;
                                end
                            end
                            status_next[sel]    = ST_IN_FLIGHT;
                            result.done_ok      = 1'b1;
                            result.out_slot     = SLOT_W'(sel);
                            result.out_sequence = newest;
                        end
                    end
                end
            end
            OP_RELEASE:
            begin
                if (status[sidx] == ST_IN_FLIGHT)
                begin
                    status_next[sidx] = ST_FREE;
                    result.done_ok    = 1'b1;
                end
            end
            default:
            begin
                result.done_ok = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/frame_buffer_slot_manager.sv
`timescale 1ns / 1ps

// Frame buffer slot manager. A producer acquires a free slot, fills it and
// finishes it (marking it ready with a fresh sequence number, or discarding
// it); each display tick either drops all ready frames while the preview is
// frozen or hands the newest ready frame to the display and drops the older
// ones; the display releases its slot when it is done. Every operation
// beat on the slave stream gives exactly one result beat on the master
// stream. The block takes one operation per clock cycle while the master
// side accepts results. On its way to the master stream the operation is
// held in an input register, the whole slot table is updated in one pass
// of logic, and the result waits in an output register. The path that
// sets the cycle time is that pass, chiefly the newest-stamp compare
// across the slots. A stalled master side holds the result register and
// then stops the slave side from accepting. The configuration channel is
// always ready; write it only while no operation is outstanding. Slots
// whose index lies beyond the present mask never hold storage and are
// never granted.
module frame_buffer_slot_manager #(
    parameter int NUM_SLOTS = fbsm_pkg::NUM_SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Operation stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fbsm_pkg::S_TDATA_W-1:0]      s_tdata,   // slot, ready_req, frozen
    input  logic [fbsm_pkg::OP_W-1:0]           s_tuser,   // op
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fbsm_pkg::M_TDATA_W-1:0]      m_tdata,   // out_slot, out_sequence
    output logic                                m_tuser,   // done_ok
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fbsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fbsm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fbsm_pkg::*;

    logic                 in_valid_reg;
    item_t                item_reg;
    logic                 out_valid_reg;
    result_t              result_reg;
    logic [STATUS_W-1:0]  status_reg [NUM_SLOTS];
    logic [SEQ_W-1:0]     stamp_reg [NUM_SLOTS];
    logic [SEQ_W-1:0]     counter_reg;
    logic                 run_enable_reg;
    logic [MASK_W-1:0]    present_mask_reg;

    logic [STATUS_W-1:0]  status_next [NUM_SLOTS];
    logic [SEQ_W-1:0]     stamp_next [NUM_SLOTS];
    logic [SEQ_W-1:0]     counter_next;
    result_t              step_result;
    item_t                item_in;
    logic                 advance;
    logic                 accept;

    // The held operation moves into the table and result register when the
    // result register is empty or being emptied in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign item_in.op        = s_tuser;
    assign item_in.slot      = s_tdata[0];
    assign item_in.ready_req = s_tdata[1];
    assign item_in.frozen    = s_tdata[2];

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.done_ok;
    assign m_tdata  = {(M_TDATA_W - SEQ_W - SLOT_W)'(0),
                       result_reg.out_sequence, result_reg.out_slot};

    fbsm_step #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_step (
        .item         (item_reg),
        .run_enable   (run_enable_reg),
        .present_mask (present_mask_reg),
        .status       (status_reg),
        .stamp        (stamp_reg),
        .counter      (counter_reg),
        .status_next  (status_next),
        .stamp_next   (stamp_next),
        .counter_next (counter_next),
        .result       (step_result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    // Slot table and frame counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                status_reg[i] <= ST_FREE;
                stamp_reg[i]  <= '0;
            end
            counter_reg <= '0;
        end
        else if (advance)
        begin
            status_reg  <= status_next;
            stamp_reg   <= stamp_next;
            counter_reg <= counter_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_enable_reg   <= 1'b0;
            present_mask_reg <= MASK_W'(3);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RUN_ENABLE:   run_enable_reg   <= cfg_data[0];
                CFG_PRESENT_MASK: present_mask_reg <= cfg_data;
                default:          run_enable_reg   <= run_enable_reg;
            endcase
        end
    end

`ifndef SYNTH
    // The frame counter only ever steps by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (counter_reg != $past(counter_reg)) |->
        (counter_reg == $past(counter_reg) + SEQ_W'(1)))
    else $error("frame counter moved by other than one");

    // A held operation facing a full, stalled result register blocks intake.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
    else $error("operation accepted while pipeline is stalled");

    // An operation that advances always leaves a result behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
    else $error("advanced operation produced no result");

    // A nonzero sequence is only reported together with success.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.out_sequence != '0) |-> result_reg.done_ok)
    else $error("sequence reported on a failed operation");
`endif

endmodule
